// ----- src/assert_macros.svh -----
// assertion macros used by the rtl top
// no dependencies; the active forms are kept out of synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CSC_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");
`define CSC_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define CSC_ASSERT(lbl, clk, rstn, prop)
`define CSC_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ----- src/csc_pkg.sv -----
// types and constants of the cloth stretch constraint block
// no dependencies
package csc_pkg;

    localparam logic [1:0] MODE_WRITE  = 2'd0;
    localparam logic [1:0] MODE_READ   = 2'd1;
    localparam logic [1:0] MODE_CONSTR = 2'd2;

    localparam int         CFG_IDX_W   = 1;
    localparam logic [0:0] CFG_MAX     = 1'b0;
    localparam logic [0:0] CFG_MIN     = 1'b1;

    localparam logic [15:0] MAX_RATIO_RST = 16'd4506;
    localparam logic [15:0] MIN_RATIO_RST = 16'd3686;

    // one stored particle; c[0] is x, c[1] y, c[2] z, signed q16.16
    typedef struct packed {
        logic             pinned;
        logic [2:0][31:0] c;
    } particle_t;

    typedef enum logic [13:0] {
        ST_IDLE  = 14'b00000000000001,
        ST_READ  = 14'b00000000000010,
        ST_DIFF  = 14'b00000000000100,
        ST_SQ    = 14'b00000000001000,
        ST_CHK   = 14'b00000000010000,
        ST_SQRT  = 14'b00000000100000,
        ST_CMP   = 14'b00000001000000,
        ST_MUL   = 14'b00000010000000,
        ST_SUM   = 14'b00000100000000,
        ST_DIV   = 14'b00001000000000,
        ST_APPLY = 14'b00010000000000,
        ST_WRA   = 14'b00100000000000,
        ST_WRB   = 14'b01000000000000,
        ST_FIN   = 14'b10000000000000
    } state_t;

endpackage

// ----- src/csc_if.sv -----
// item and result channels of the cloth stretch constraint block
// no dependencies
interface csc_item_if;
    logic               valid;
    logic               ready;
    logic        [1:0]  mode;
    logic        [9:0]  index_a;
    logic        [9:0]  index_b;
    logic        [31:0] rest_length;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic               pinned;

    modport source (output valid, mode, index_a, index_b, rest_length, pos_x, pos_y,
                    pos_z, pinned, input ready);
    modport sink   (input valid, mode, index_a, index_b, rest_length, pos_x, pos_y,
                    pos_z, pinned, output ready);
endinterface

interface csc_result_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic               out_pinned;
    logic               corrected;
    logic               degenerate;

    modport source (output valid, out_x, out_y, out_z, out_pinned, corrected,
                    degenerate, input ready);
    modport sink   (input valid, out_x, out_y, out_z, out_pinned, corrected,
                    degenerate, output ready);
endinterface

// ----- src/cloth_stretch_constraint.sv -----
// cloth stretch constraint: particle memory with a sequenced constraint datapath
// depends on csc_pkg, csc_if.sv and assert_macros.svh
//
//   channel  dir  handshake        payload
//   item     in   valid / ready    mode, index_a, index_b, rest_length, pos_*, pinned
//   result   out  valid / ready    out_x/y/z, out_pinned, corrected, degenerate
//   cfg      in   cfg_write        cfg_index, cfg_data
//
// one item at a time: the next item is taken only once the current write, read or constraint is done
// the constraint time is set by the 35-step square root and the 38-step divider
// (three axes divide side by side), with two memory read ports and one write port
// the memory needs no clearing after reset; an item is taken whenever the
// sequencer is idle, even while the previous result still waits in the output register
`include "assert_macros.svh"

module cloth_stretch_constraint
    import csc_pkg::*;
#(
    parameter int NUM_PARTICLES = 1024
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]          cfg_data,
    csc_item_if.sink             item,
    csc_result_if.source         result
);

    localparam int          AW = $clog2(NUM_PARTICLES);
    localparam logic [16:0] NP = 17'(NUM_PARTICLES);

    function automatic logic [31:0] sat32(input logic signed [40:0] v);
        logic [31:0] r;
        if (v > 41'sd2147483647)
            r = 32'h7fffffff;
        else if (v < -41'sd2147483648)
            r = 32'h80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    state_t state_reg, state_next;
    logic [5:0]  cnt_reg;
    logic [15:0] max_ratio_reg, min_ratio_reg;
    logic        out_valid_reg;

    particle_t   mem [NUM_PARTICLES];
    particle_t   rd_a, rd_b, a_reg, b_reg, res_reg, out_reg;
    logic        res_corr_reg, res_deg_reg, out_corr_reg, out_deg_reg;
    logic [AW-1:0] addr_a_reg, addr_b_reg;
    logic [1:0]  mode_reg;
    logic [31:0] rest_reg;

    logic signed [32:0] d_reg [3];
    logic [32:0] m [3];
    logic [32:0] m_sel;
    logic [65:0] sq_reg, acc_reg;
    logic [69:0] rad_reg;
    logic [37:0] srem_reg;
    logic [34:0] root_reg;
    logic [35:0] maxb_reg, minb_reg, dmag_reg;
    logic        dneg_reg;
    logic [50:0] pp_lo_reg [3];
    logic [50:0] pp_hi_reg [3];
    logic [34:0] qrem_reg [3];
    logic [37:0] dq_reg [3];

    logic        accept, out_free;
    logic [16:0] ia_ext, ib_ext;
    logic        a_ok, b_ok;
    logic        mem_we;
    logic [AW-1:0] mem_waddr;
    particle_t   mem_wdata, in_part;

    logic [37:0] srem_try, strial;
    logic [47:0] bmax_full, bmin_full;
    logic [35:0] len36, target;
    logic        gt_max, lt_min;
    logic signed [36:0] delta;
    logic [68:0] prod [3];
    logic [35:0] r2 [3];
    logic        ge [3];
    particle_t   a_new, b_new;

    assign accept   = item.valid && item.ready;
    assign out_free = !out_valid_reg || result.ready;
    assign ia_ext   = {7'b0, item.index_a};
    assign ib_ext   = {7'b0, item.index_b};
    assign a_ok     = ia_ext < NP;
    assign b_ok     = ib_ext < NP;

    assign in_part.pinned = item.pinned;
    assign in_part.c[0]   = item.pos_x;
    assign in_part.c[1]   = item.pos_y;
    assign in_part.c[2]   = item.pos_z;

    assign item.ready        = (state_reg == ST_IDLE);
    assign result.valid      = out_valid_reg;
    assign result.out_x      = out_reg.c[0];
    assign result.out_y      = out_reg.c[1];
    assign result.out_z      = out_reg.c[2];
    assign result.out_pinned = out_reg.pinned;
    assign result.corrected  = out_corr_reg;
    assign result.degenerate = out_deg_reg;

    // datapath arithmetic
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            m[k] = d_reg[k][32] ? 33'(-d_reg[k]) : 33'(d_reg[k]);
        end
        case (cnt_reg[1:0])
            2'd0:    m_sel = m[0];
            2'd1:    m_sel = m[1];
            default: m_sel = m[2];
        endcase

        srem_try  = {srem_reg[35:0], rad_reg[69:68]};
        strial    = {1'b0, root_reg, 2'b01};
        bmax_full = {16'b0, rest_reg} * {32'b0, max_ratio_reg};
        bmin_full = {16'b0, rest_reg} * {32'b0, min_ratio_reg};

        len36  = {1'b0, root_reg};
        gt_max = len36 > maxb_reg;
        lt_min = len36 < minb_reg;
        target = gt_max ? maxb_reg : minb_reg;
        delta  = $signed({1'b0, len36}) - $signed({1'b0, target});

        for (int k = 0; k < 3; k++)
        begin
            prod[k] = {18'b0, pp_lo_reg[k]} + {pp_hi_reg[k], 18'b0};
            r2[k]   = {qrem_reg[k], dq_reg[k][37]};
            ge[k]   = r2[k] >= len36;
        end
    end

    // correction of the free particle or particles, one lane per axis
    always_comb
    begin
        logic signed [39:0] f;
        logic signed [39:0] h;
        logic signed [39:0] g;
        logic signed [40:0] av;
        logic signed [40:0] bv;
        logic               neg;
        a_new = a_reg;
        b_new = b_reg;
        for (int k = 0; k < 3; k++)
        begin
            neg = d_reg[k][32] ^ dneg_reg;
            f   = neg ? -$signed({2'b0, dq_reg[k]}) : $signed({2'b0, dq_reg[k]});
            // halve toward zero
            h   = $signed(f + {39'b0, f[39]}) >>> 1;
            g   = f - h;
            av  = 41'($signed(a_reg.c[k]));
            bv  = 41'($signed(b_reg.c[k]));
            if (!a_reg.pinned && !b_reg.pinned)
            begin
                a_new.c[k] = sat32(av - 41'(h));
                b_new.c[k] = sat32(bv + 41'(g));
            end
            else if (!a_reg.pinned)
                a_new.c[k] = sat32(av - 41'(f));
            else
                b_new.c[k] = sat32(bv + 41'(f));
        end
    end

    // memory write port
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = addr_a_reg;
        mem_wdata = a_reg;
        case (state_reg)
            ST_IDLE:
            begin
                mem_we    = accept && item.mode == MODE_WRITE && a_ok;
                mem_waddr = ia_ext[AW-1:0];
                mem_wdata = in_part;
            end
            ST_WRA:
                mem_we = 1'b1;
            ST_WRB:
            begin
                mem_we    = 1'b1;
                mem_waddr = addr_b_reg;
                mem_wdata = b_reg;
            end
            default:
                mem_we = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rd_a <= mem[addr_a_reg];
        rd_b <= mem[addr_b_reg];
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (accept)
                begin
                    case (item.mode)
                        MODE_READ:   state_next = a_ok ? ST_READ : ST_FIN;
                        MODE_CONSTR: state_next = (a_ok && b_ok) ? ST_READ : ST_FIN;
                        default:     state_next = ST_FIN;
                    endcase
                end
            ST_READ:  state_next = ST_DIFF;
            ST_DIFF:  state_next = (mode_reg == MODE_READ) ? ST_FIN : ST_SQ;
            ST_SQ:    if (cnt_reg == 6'd3) state_next = ST_CHK;
            ST_CHK:   state_next = (acc_reg == 66'd0) ? ST_FIN : ST_SQRT;
            ST_SQRT:  if (cnt_reg == 6'd0) state_next = ST_CMP;
            ST_CMP:
                if ((!gt_max && !lt_min) || (a_reg.pinned && b_reg.pinned))
                    state_next = ST_FIN;
                else
                    state_next = ST_MUL;
            ST_MUL:   if (cnt_reg == 6'd2) state_next = ST_SUM;
            ST_SUM:   state_next = ST_DIV;
            ST_DIV:   if (cnt_reg == 6'd0) state_next = ST_APPLY;
            ST_APPLY: state_next = ST_WRA;
            ST_WRA:   state_next = ST_WRB;
            ST_WRB:   state_next = ST_FIN;
            ST_FIN:   if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= 6'd0;
            out_valid_reg <= 1'b0;
            max_ratio_reg <= MAX_RATIO_RST;
            min_ratio_reg <= MIN_RATIO_RST;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_MAX: max_ratio_reg <= cfg_data;
                    CFG_MIN: min_ratio_reg <= cfg_data;
                    default: max_ratio_reg <= max_ratio_reg;
                endcase
            end
            case (state_reg)
                ST_DIFF, ST_CMP: cnt_reg <= 6'd0;
                ST_SQ, ST_MUL:   cnt_reg <= cnt_reg + 6'd1;
                ST_CHK:          cnt_reg <= 6'd34;
                ST_SUM:          cnt_reg <= 6'd37;
                ST_SQRT, ST_DIV: cnt_reg <= cnt_reg - 6'd1;
                default:         cnt_reg <= 6'd0;
            endcase
            if (state_reg == ST_FIN && out_free)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
                if (accept)
                begin
                    mode_reg     <= item.mode;
                    addr_a_reg   <= ia_ext[AW-1:0];
                    addr_b_reg   <= ib_ext[AW-1:0];
                    rest_reg     <= item.rest_length;
                    res_reg      <= (item.mode == MODE_WRITE && a_ok) ? in_part : '0;
                    res_corr_reg <= 1'b0;
                    res_deg_reg  <= 1'b0;
                end
            ST_DIFF:
            begin
                a_reg   <= rd_a;
                b_reg   <= rd_b;
                res_reg <= rd_a;
                acc_reg <= 66'd0;
                for (int k = 0; k < 3; k++)
                begin
                    d_reg[k] <= 33'($signed(rd_a.c[k])) - 33'($signed(rd_b.c[k]));
                end
            end
            ST_SQ:
            begin
                if (cnt_reg != 6'd3)
                    sq_reg <= {33'b0, m_sel} * {33'b0, m_sel};
                if (cnt_reg != 6'd0)
                    acc_reg <= acc_reg + sq_reg;
            end
            ST_CHK:
            begin
                rad_reg     <= {4'b0, acc_reg};
                srem_reg    <= 38'd0;
                root_reg    <= 35'd0;
                maxb_reg    <= bmax_full[47:12];
                minb_reg    <= bmin_full[47:12];
                res_deg_reg <= (acc_reg == 66'd0);
            end
            ST_SQRT:
            begin
                // one root bit a cycle, two radicand bits shifted in
                rad_reg <= {rad_reg[67:0], 2'b00};
                if (srem_try >= strial)
                begin
                    srem_reg <= srem_try - strial;
                    root_reg <= {root_reg[33:0], 1'b1};
                end
                else
                begin
                    srem_reg <= srem_try;
                    root_reg <= {root_reg[33:0], 1'b0};
                end
            end
            ST_CMP:
            begin
                dneg_reg <= delta[36];
                dmag_reg <= delta[36] ? 36'(-delta) : 36'(delta);
            end
            ST_MUL:
                for (int k = 0; k < 3; k++)
                begin
                    if (cnt_reg[1:0] == 2'(k))
                    begin
                        pp_lo_reg[k] <= {18'b0, m_sel} * {33'b0, dmag_reg[17:0]};
                        pp_hi_reg[k] <= {18'b0, m_sel} * {33'b0, dmag_reg[35:18]};
                    end
                end
            ST_SUM:
                // quotient stays below 2^38, so the top bits start below the length
                for (int k = 0; k < 3; k++)
                begin
                    qrem_reg[k] <= {4'b0, prod[k][68:38]};
                    dq_reg[k]   <= prod[k][37:0];
                end
            ST_DIV:
                for (int k = 0; k < 3; k++)
                begin
                    qrem_reg[k] <= ge[k] ? 35'(r2[k] - len36) : 35'(r2[k]);
                    dq_reg[k]   <= {dq_reg[k][36:0], ge[k]};
                end
            ST_APPLY:
            begin
                a_reg <= a_new;
                b_reg <= b_new;
            end
            ST_WRA:
            begin
                res_reg      <= a_reg;
                res_corr_reg <= 1'b1;
            end
            ST_FIN:
                if (out_free)
                begin
                    out_reg      <= res_reg;
                    out_corr_reg <= res_corr_reg;
                    out_deg_reg  <= res_deg_reg;
                end
            default:
                rest_reg <= rest_reg;
        endcase
    end

    `CSC_ASSERT(a_wr_phase, clk, rst_n, mem_we |-> (state_reg == ST_IDLE || state_reg == ST_WRA || state_reg == ST_WRB))
    `CSC_ASSERT(a_div_rem, clk, rst_n, (state_reg == ST_DIV) |-> (qrem_reg[0] < len36[34:0] && qrem_reg[1] < len36[34:0] && qrem_reg[2] < len36[34:0]))
    `CSC_ASSERT(a_div_exit, clk, rst_n, (state_reg == ST_DIV && cnt_reg == 6'd0) |=> (state_reg == ST_APPLY))
    `CSC_ASSERT(a_flags, clk, rst_n, out_valid_reg |-> !(out_corr_reg && out_deg_reg))

endmodule

// ----- verif/tb_top.sv -----
// self-checking testbench for the cloth stretch constraint block
// depends on csc_pkg, csc_if.sv and the rtl top; carries its own particle predictor
`timescale 1ns / 1ps

module tb_top;
    import csc_pkg::*;

    typedef struct {
        logic        [1:0]  mode;
        logic        [9:0]  ia;
        logic        [9:0]  ib;
        logic        [31:0] rest;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               pin;
    } beat_t;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               pin;
        logic               corr;
        logic               degen;
    } answer_t;

    typedef struct {
        logic signed [31:0] c [3];
        logic               pin;
    } point_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [15:0]          cfg_data;

    csc_item_if   item_ch ();
    csc_result_if res_ch ();

    cloth_stretch_constraint uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item_ch),
        .result    (res_ch)
    );

    point_t   cloth [1024];
    bit       touched [1024];
    int       live_idx [$];
    logic [15:0] max_ratio;
    logic [15:0] min_ratio;

    beat_t    item_q [$];
    answer_t  answer_q [$];

    int       send_idle;
    int       recv_stall;
    int       errs;
    int       checked;
    int       n_corr;
    int       n_degen;
    int       cycles;
    bit       hold_go;
    bit       hold_seen;
    int       hold_left;

    localparam int CYCLE_LIMIT = 1000000;

    always #5 clk = ~clk;

    function automatic logic signed [31:0] clamp32(longint v);
        if (v > 64'sd2147483647)
            return 32'sh7fffffff;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic logic [127:0] dist_sq(int a, int b);
        logic [127:0] s;
        longint       d;
        logic [63:0]  m;
        s = 0;
        for (int k = 0; k < 3; k++)
        begin
            d = longint'(cloth[a].c[k]) - longint'(cloth[b].c[k]);
            m = (d < 0) ? -d : d;
            s += 128'(m) * 128'(m);
        end
        return s;
    endfunction

    function automatic logic [63:0] root_floor(logic [127:0] s);
        logic [63:0]  r;
        logic [63:0]  c;
        r = 0;
        for (int bitn = 34; bitn >= 0; bitn--)
        begin
            c = r | (64'd1 << bitn);
            if (128'(c) * 128'(c) <= s)
                r = c;
        end
        return r;
    endfunction

    // advances the particle memory by one beat and returns the answer it gives
    function automatic answer_t project(beat_t it);
        answer_t      r;
        point_t       pa;
        point_t       pb;
        logic [127:0] s;
        logic [63:0]  len;
        logic [63:0]  maxb;
        logic [63:0]  minb;
        logic [63:0]  target;
        logic [63:0]  m;
        logic [63:0]  dmag;
        logic [127:0] q;
        longint       d [3];
        longint       f [3];
        longint       delta;
        longint       h;
        r = '{default: 0};
        if (it.mode == MODE_WRITE)
        begin
            cloth[it.ia].c[0] = it.x;
            cloth[it.ia].c[1] = it.y;
            cloth[it.ia].c[2] = it.z;
            cloth[it.ia].pin  = it.pin;
            r = '{it.x, it.y, it.z, it.pin, 1'b0, 1'b0};
            return r;
        end
        if (it.mode == MODE_READ)
        begin
            pa = cloth[it.ia];
            r = '{pa.c[0], pa.c[1], pa.c[2], pa.pin, 1'b0, 1'b0};
            return r;
        end
        if (it.mode != MODE_CONSTR)
            return r;
        pa = cloth[it.ia];
        pb = cloth[it.ib];
        r = '{pa.c[0], pa.c[1], pa.c[2], pa.pin, 1'b0, 1'b0};
        s = dist_sq(it.ia, it.ib);
        if (s == 0)
        begin
            r.degen = 1'b1;
            return r;
        end
        len  = root_floor(s);
        maxb = (64'(it.rest) * 64'(max_ratio)) >> 12;
        minb = (64'(it.rest) * 64'(min_ratio)) >> 12;
        if (len > maxb)
            target = maxb;
        else if (len < minb)
            target = minb;
        else
            return r;
        if (pa.pin && pb.pin)
            return r;
        delta = longint'(len) - longint'(target);
        dmag  = (delta < 0) ? -delta : delta;
        for (int k = 0; k < 3; k++)
        begin
            d[k] = longint'(pa.c[k]) - longint'(pb.c[k]);
            m    = (d[k] < 0) ? -d[k] : d[k];
            q    = (128'(m) * 128'(dmag)) / 128'(len);
            f[k] = ((d[k] < 0) != (delta < 0)) ? -longint'(q[63:0]) : longint'(q[63:0]);
            if (!pa.pin && !pb.pin)
            begin
                h = f[k] / 2;
                cloth[it.ia].c[k] = clamp32(longint'(pa.c[k]) - h);
                cloth[it.ib].c[k] = clamp32(longint'(pb.c[k]) + (f[k] - h));
            end
            else if (!pa.pin)
                cloth[it.ia].c[k] = clamp32(longint'(pa.c[k]) - f[k]);
            else
                cloth[it.ib].c[k] = clamp32(longint'(pb.c[k]) + f[k]);
        end
        pa = cloth[it.ia];
        r = '{pa.c[0], pa.c[1], pa.c[2], pa.pin, 1'b1, 1'b0};
        return r;
    endfunction

    task automatic queue_beat(beat_t it);
        if (it.mode == MODE_WRITE && !touched[it.ia])
        begin
            touched[it.ia] = 1;
            live_idx = {live_idx, int'(it.ia)};
        end
        answer_q = {answer_q, project(it)};
        item_q   = {item_q, it};
    endtask

    task automatic put_point(int idx, logic [31:0] x, logic [31:0] y, logic [31:0] z,
                             logic pin);
        beat_t it;
        it = '{MODE_WRITE, idx[9:0], 10'($urandom), $urandom, x, y, z, pin};
        queue_beat(it);
    endtask

    task automatic pull_pair(int a, int b, logic [31:0] rest);
        beat_t it;
        it = '{MODE_CONSTR, a[9:0], b[9:0], rest, $urandom, $urandom, $urandom,
               1'($urandom)};
        queue_beat(it);
    endtask

    function automatic logic [31:0] pick_coord();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return 32'($urandom_range(0, 32'h200000)) - 32'h100000;
        if (r < 8)
            return $urandom;
        return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
    endfunction

    function automatic logic [31:0] pick_rest(int a, int b);
        logic [63:0] len;
        logic [63:0] v;
        int          r;
        r   = $urandom_range(0, 9);
        len = root_floor(dist_sq(a, b));
        if (r < 7)
        begin
            v = (len * 64'($urandom_range(40, 250))) / 100;
            return (v > 64'hffffffff) ? 32'hffffffff : v[31:0];
        end
        if (r == 7)
            return $urandom;
        return (r == 8) ? 32'd0 : 32'hffffffff;
    endfunction

    task automatic random_beats(int count);
        beat_t it;
        int    r;
        int    a;
        int    b;
        for (int i = 0; i < count; i++)
        begin
            r  = $urandom_range(0, 99);
            it = '{MODE_READ, 10'($urandom), 10'($urandom), $urandom, $urandom,
                   $urandom, $urandom, 1'($urandom)};
            if (r < 18)
            begin
                it.mode = MODE_WRITE;
                it.x    = pick_coord();
                it.y    = pick_coord();
                it.z    = pick_coord();
                it.pin  = ($urandom_range(0, 3) == 0);
            end
            else if (r < 30)
                it.ia = 10'(live_idx[$urandom_range(0, live_idx.size() - 1)]);
            else if (r < 33)
                it.mode = 2'b11;
            else
            begin
                a = live_idx[$urandom_range(0, live_idx.size() - 1)];
                b = ($urandom_range(0, 9) == 0) ? a
                    : live_idx[$urandom_range(0, live_idx.size() - 1)];
                it.mode = MODE_CONSTR;
                it.ia   = 10'(a);
                it.ib   = 10'(b);
                it.rest = pick_rest(a, b);
            end
            queue_beat(it);
        end
    endtask

    task automatic set_ratio(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx == CFG_MAX)
            max_ratio = val;
        else
            min_ratio = val;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic drain();
        while (item_q.size() != 0 || item_ch.valid || answer_q.size() != 0)
            @(posedge clk);
        repeat (120) @(posedge clk);
    endtask

    // sender
    always @(posedge clk)
    begin : driver
        beat_t it;
        if (!rst_n)
            item_ch.valid <= 1'b0;
        else if (!item_ch.valid || item_ch.ready)
        begin
            if (item_q.size() != 0 && $urandom_range(0, 99) >= send_idle)
            begin
                it = item_q.pop_front();
                item_ch.valid       <= 1'b1;
                item_ch.mode        <= it.mode;
                item_ch.index_a     <= it.ia;
                item_ch.index_b     <= it.ib;
                item_ch.rest_length <= it.rest;
                item_ch.pos_x       <= it.x;
                item_ch.pos_y       <= it.y;
                item_ch.pos_z       <= it.z;
                item_ch.pinned      <= it.pin;
            end
            else
                item_ch.valid <= 1'b0;
        end
    end

    // long receiver hold-off so the block backs up into its input
    always @(posedge clk)
    begin
        if (hold_go && !hold_seen)
        begin
            hold_left <= 400;
            hold_seen <= 1'b1;
        end
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    always @(posedge clk)
    begin
        if (!rst_n || hold_left > 0)
            res_ch.ready <= 1'b0;
        else
            res_ch.ready <= ($urandom_range(0, 99) >= recv_stall);
    end

    always @(posedge clk)
    begin : monitor
        answer_t e;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (answer_q.size() == 0)
            begin
                errs++;
                if (errs <= 10)
                    $display("result beat with nothing expected: x=%h y=%h z=%h",
                             res_ch.out_x, res_ch.out_y, res_ch.out_z);
            end
            else
            begin
                e = answer_q.pop_front();
                checked++;
                if (e.corr)
                    n_corr++;
                if (e.degen)
                    n_degen++;
                if (res_ch.out_x !== e.x || res_ch.out_y !== e.y || res_ch.out_z !== e.z
                    || res_ch.out_pinned !== e.pin || res_ch.corrected !== e.corr
                    || res_ch.degenerate !== e.degen)
                begin
                    errs++;
                    if (errs <= 10)
                        $display("mismatch #%0d exp %h %h %h p%b c%b d%b got %h %h %h p%b c%b d%b",
                                 checked, e.x, e.y, e.z, e.pin, e.corr, e.degen,
                                 res_ch.out_x, res_ch.out_y, res_ch.out_z,
                                 res_ch.out_pinned, res_ch.corrected, res_ch.degenerate);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d answers outstanding", cycles,
                     answer_q.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        cfg_write    = 1'b0;
        cfg_index    = CFG_MAX;
        cfg_data     = 16'd0;
        item_ch.valid       = 1'b0;
        item_ch.mode        = MODE_WRITE;
        item_ch.index_a     = 10'd0;
        item_ch.index_b     = 10'd0;
        item_ch.rest_length = 32'd0;
        item_ch.pos_x       = 32'd0;
        item_ch.pos_y       = 32'd0;
        item_ch.pos_z       = 32'd0;
        item_ch.pinned      = 1'b0;
        res_ch.ready = 1'b0;
        send_idle    = 0;
        recv_stall   = 0;
        errs         = 0;
        checked      = 0;
        n_corr       = 0;
        n_degen      = 0;
        cycles       = 0;
        hold_go      = 1'b0;
        hold_seen    = 1'b0;
        hold_left    = 0;
        max_ratio    = MAX_RATIO_RST;
        min_ratio    = MIN_RATIO_RST;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: begin set_ratio(CFG_MAX, MAX_RATIO_RST); set_ratio(CFG_MIN, MIN_RATIO_RST); end
                1: begin set_ratio(CFG_MAX, 16'hffff); set_ratio(CFG_MIN, 16'h0000); end
                2: begin set_ratio(CFG_MAX, 16'h0000); set_ratio(CFG_MIN, 16'hffff); end
                3: begin set_ratio(CFG_MAX, 16'd4096); set_ratio(CFG_MIN, 16'd4096); end
                default:
                begin
                    set_ratio(CFG_MAX, 16'($urandom_range(4096, 6000)));
                    set_ratio(CFG_MIN, 16'($urandom_range(2000, 4096)));
                end
            endcase
            send_idle  = (ph == 1) ? 58 : (ph == 3) ? 25 : 0;
            recv_stall = (ph == 2) ? 58 : (ph == 3) ? 25 : 0;
            if (ph == 0)
            begin
                put_point(0, 0, 0, 0, 1'b0);
                put_point(1023, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1'b0);
                put_point(1, 32'h80000000, 32'h80000000, 32'h80000000, 1'b0);
                queue_beat('{MODE_READ, 10'd1023, 10'd0, 32'hffffffff, 32'hffffffff,
                             32'hffffffff, 32'hffffffff, 1'b1});
                pull_pair(0, 0, 32'h10000);             // same particle twice
                put_point(2, 32'h30000, 32'h40000, 32'h0, 1'b0);
                pull_pair(0, 2, 32'h10000);             // over-stretched
                pull_pair(0, 2, pick_rest(0, 2));
                put_point(2, 32'h30000, 32'h40000, 32'h0, 1'b0);
                pull_pair(0, 2, 32'h100000);            // too short
                put_point(3, 32'hfffe0000, 32'h8000, 32'h1234, 1'b1);
                pull_pair(3, 2, 32'h8000);              // only second free
                pull_pair(2, 3, 32'h400000);            // only first free
                put_point(4, 32'h50000, 32'h0, 32'hfff00000, 1'b1);
                pull_pair(3, 4, 32'h1);                 // both pinned
                queue_beat('{2'b11, 10'h3ff, 10'h3ff, 32'hffffffff, 32'hffffffff,
                             32'hffffffff, 32'hffffffff, 1'b1});
                put_point(5, 32'h7fffff00, 32'h0, 32'h0, 1'b0);
                put_point(6, 32'h7ffff000, 32'h0, 32'h0, 1'b0);
                pull_pair(5, 6, 32'hffffffff);          // pushed past the coordinate limit
                pull_pair(1023, 1, 32'h0);              // widest distance
                pull_pair(1, 1023, 32'hffffffff);
                queue_beat('{MODE_READ, 10'd6, 10'd0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0});
                put_point(7, 32'h0, 32'h0, 32'h0, 1'b1);
                pull_pair(7, 0, 32'h10000);             // pinned first, free second
            end
            if (ph == 4)
                hold_go <= 1'b1;
            random_beats(150);
            drain();
        end

        $display("checked %0d result beats (%0d corrected, %0d degenerate) over 5 ratio settings",
                 checked, n_corr, n_degen);
        $display("%0d particles touched, %0d mismatches", live_idx.size(), errs);
        if (errs == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
